// ----- hdl/okvt_pkg.sv -----
`timescale 1ns / 1ps

package okvt_pkg;

  // Default number of cells in the table.
  localparam int DEFAULT_CAPACITY = 64;

  // Field widths of the command and result beats.
  localparam int CMD_W  = 3;
  localparam int KEY_W  = 16;
  localparam int WGT_W  = 32;
  localparam int RPOS_W = 6;
  localparam int STAT_W = 3;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_DONE    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MISSING = 3'd1;
  localparam logic [STAT_W-1:0] STAT_PRESENT = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 3'd4;

  // Command broadcast to every cell.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  key;
    logic [WGT_W-1:0]  weight;
    logic [RPOS_W-1:0] rpos;
  } cmd_t;

  // Store updates issued by the controller for one cycle.
  typedef struct packed {
    logic add_en;
    logic set_en;
    logic del_en;
  } act_t;

endpackage

// ----- hdl/okvt_cell.sv -----
`timescale 1ns / 1ps

module okvt_cell
  import okvt_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int INDEX    = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  input  act_t                        act_i,
  input  logic [$clog2(CAPACITY+1)-1:0] count_i,
  input  logic [KEY_W-1:0]            nbr_key_i,
  input  logic [WGT_W-1:0]            nbr_weight_i,
  output logic [KEY_W-1:0]            key_o,
  output logic [WGT_W-1:0]            weight_o,
  input  logic                        bus_found_i,
  input  logic [$clog2(CAPACITY)-1:0] bus_pos_i,
  input  logic [KEY_W-1:0]            bus_key_i,
  input  logic [WGT_W-1:0]            bus_weight_i,
  output logic                        bus_found_o,
  output logic [$clog2(CAPACITY)-1:0] bus_pos_o,
  output logic [KEY_W-1:0]            bus_key_o,
  output logic [WGT_W-1:0]            bus_weight_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (IW > RPOS_W) ? IW : RPOS_W;

  logic [KEY_W-1:0] key_q, key_d;
  logic [WGT_W-1:0] weight_q, weight_d;
  logic             found_q;
  logic [IW-1:0]    pos_q;
  logic [KEY_W-1:0] bkey_q;
  logic [WGT_W-1:0] bweight_q;
  logic             occupied;
  logic             key_cmd;
  logic             hit;

  assign occupied = CW'(INDEX) < count_i;
  assign key_cmd  = (cmd_i.command == CMD_ADD) || (cmd_i.command == CMD_SET) ||
                    (cmd_i.command == CMD_DELETE) || (cmd_i.command == CMD_SEARCH);
  assign hit = occupied &&
               ((key_cmd && (key_q == cmd_i.key)) ||
                ((cmd_i.command == CMD_READ) && (PW'(cmd_i.rpos) == PW'(INDEX))));

  // Delete closes the gap: this cell and all above the hit take the upper neighbor.
  always_comb begin
    key_d    = key_q;
    weight_d = weight_q;
    if (act_i.del_en && (bus_found_i || hit)) begin
      key_d    = nbr_key_i;
      weight_d = nbr_weight_i;
    end else if (act_i.add_en && (CW'(INDEX) == count_i)) begin
      key_d    = cmd_i.key;
      weight_d = cmd_i.weight;
    end else if (act_i.set_en && hit) begin
      weight_d = cmd_i.weight;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    weight_q <= weight_d;
  end

  // The first hit along the chain wins; later cells pass it on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= bus_found_i || hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bus_found_i || !hit) begin
      pos_q     <= bus_pos_i;
      bkey_q    <= bus_key_i;
      bweight_q <= bus_weight_i;
    end else begin
      pos_q     <= IW'(INDEX);
      bkey_q    <= key_q;
      bweight_q <= weight_q;
    end
  end

  assign key_o        = key_q;
  assign weight_o     = weight_q;
  assign bus_found_o  = found_q;
  assign bus_pos_o    = pos_q;
  assign bus_key_o    = bkey_q;
  assign bus_weight_o = bweight_q;

endmodule

// ----- hdl/ordered_key_value_table.sv -----
`timescale 1ns / 1ps
// A command beat is accepted only while the controller is idle, so the table takes no new
// command until the previous one has run through the lookup chain of cells and been committed.
// The result register lets the next command start while the previous result waits.
// Reset clears the entry count and all control state; the cell stores are not reset.

module ordered_key_value_table
  import okvt_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [KEY_W-1:0]   vertex_key_i,
  input  logic [WGT_W-1:0]   weight_bits_i,
  input  logic [RPOS_W-1:0]  read_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [POS_W-1:0]   position_o,
  output logic [CNT_W-1:0]   entry_count_o,
  output logic [KEY_W-1:0]   key_out_o,
  output logic [WGT_W-1:0]   weight_out_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  // The controller idles until a command beat arrives, lets the lookup wave run through
  // the whole chain, then applies the update and loads the result register once it is free.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  state_e           state_q, state_d;
  cmd_t             cmd_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    wait_q, wait_d;
  logic             out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [POS_W-1:0] position_q, position_d;
  logic [KEY_W-1:0] key_out_q, key_out_d;
  logic [WGT_W-1:0] weight_out_q, weight_out_d;
  logic [CNT_W-1:0] entry_count_q;
  logic             accept;
  logic             out_free;
  logic             commit;
  act_t             act;

  // Lookup chain: the bus enters cell 0 empty and leaves the last cell with the first hit.
  logic              bus_found  [CAPACITY+1];
  logic [IW-1:0]     bus_pos    [CAPACITY+1];
  logic [KEY_W-1:0]  bus_key    [CAPACITY+1];
  logic [WGT_W-1:0]  bus_weight [CAPACITY+1];
  logic [KEY_W-1:0]  cell_key    [CAPACITY];
  logic [WGT_W-1:0]  cell_weight [CAPACITY];

  assign bus_found[0]  = 1'b0;
  assign bus_pos[0]    = '0;
  assign bus_key[0]    = '0;
  assign bus_weight[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] nbr_key;
    logic [WGT_W-1:0] nbr_weight;
    // The top cell has no upper neighbor; what it loads on a delete lies beyond the count.
    if (i == CAPACITY - 1) begin : g_top
      assign nbr_key    = cell_key[i];
      assign nbr_weight = cell_weight[i];
    end else begin : g_mid
      assign nbr_key    = cell_key[i+1];
      assign nbr_weight = cell_weight[i+1];
    end

    okvt_cell #(
      .CAPACITY(CAPACITY),
      .INDEX   (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd_q),
      .act_i       (act),
      .count_i     (count_q),
      .nbr_key_i   (nbr_key),
      .nbr_weight_i(nbr_weight),
      .key_o       (cell_key[i]),
      .weight_o    (cell_weight[i]),
      .bus_found_i (bus_found[i]),
      .bus_pos_i   (bus_pos[i]),
      .bus_key_i   (bus_key[i]),
      .bus_weight_i(bus_weight[i]),
      .bus_found_o (bus_found[i+1]),
      .bus_pos_o   (bus_pos[i+1]),
      .bus_key_o   (bus_key[i+1]),
      .bus_weight_o(bus_weight[i+1])
    );
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // The result register is free when it is empty or its beat leaves this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == S_UPDATE) && out_free;

  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SEARCH;
          wait_d  = CW'(CAPACITY - 1);
        end
      end
      S_SEARCH: begin
        // The wave has to pass the register of every cell before the last cell holds its answer.
        if (wait_q == '0) begin
          state_d = S_UPDATE;
        end else begin
          wait_d = wait_q - 1'b1;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Decide the result and the store update from the answer of the lookup chain.
  always_comb begin
    act          = '0;
    count_d      = count_q;
    status_d     = STAT_RANGE;
    position_d   = '0;
    key_out_d    = '0;
    weight_out_d = '0;
    unique case (cmd_q.command)
      CMD_ADD: begin
        if (bus_found[CAPACITY]) begin
          status_d     = STAT_PRESENT;
          position_d   = POS_W'(bus_pos[CAPACITY]);
          key_out_d    = bus_key[CAPACITY];
          weight_out_d = bus_weight[CAPACITY];
        end else if (count_q >= CW'(CAPACITY)) begin
          status_d = STAT_FULL;
        end else begin
          act.add_en   = commit;
          count_d      = count_q + 1'b1;
          status_d     = STAT_DONE;
          position_d   = POS_W'(count_q);
          key_out_d    = cmd_q.key;
          weight_out_d = cmd_q.weight;
        end
      end
      CMD_SET: begin
        if (bus_found[CAPACITY]) begin
          act.set_en   = commit;
          status_d     = STAT_DONE;
          position_d   = POS_W'(bus_pos[CAPACITY]);
          key_out_d    = bus_key[CAPACITY];
          weight_out_d = cmd_q.weight;
        end else begin
          status_d = STAT_MISSING;
        end
      end
      CMD_DELETE: begin
        if (bus_found[CAPACITY]) begin
          act.del_en   = commit;
          count_d      = count_q - 1'b1;
          status_d     = STAT_DONE;
          position_d   = POS_W'(bus_pos[CAPACITY]);
          key_out_d    = bus_key[CAPACITY];
          weight_out_d = bus_weight[CAPACITY];
        end else begin
          status_d = STAT_MISSING;
        end
      end
      CMD_SEARCH: begin
        if (bus_found[CAPACITY]) begin
          status_d     = STAT_DONE;
          position_d   = POS_W'(bus_pos[CAPACITY]);
          key_out_d    = bus_key[CAPACITY];
          weight_out_d = bus_weight[CAPACITY];
        end else begin
          status_d = STAT_MISSING;
        end
      end
      CMD_READ: begin
        position_d = cmd_q.rpos;
        if (bus_found[CAPACITY]) begin
          status_d     = STAT_DONE;
          key_out_d    = bus_key[CAPACITY];
          weight_out_d = bus_weight[CAPACITY];
        end else begin
          status_d = STAT_RANGE;
        end
      end
      default: begin
        status_d = STAT_RANGE;
      end
    endcase
  end

  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.command <= command_i;
      cmd_q.key     <= vertex_key_i;
      cmd_q.weight  <= weight_bits_i;
      cmd_q.rpos    <= read_position_i;
    end
    if (commit) begin
      status_q      <= status_d;
      position_q    <= position_d;
      key_out_q     <= key_out_d;
      weight_out_q  <= weight_out_d;
      entry_count_q <= CNT_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign position_o    = position_q;
  assign entry_count_o = entry_count_q;
  assign key_out_o     = key_out_q;
  assign weight_out_o  = weight_out_q;

  // The count never grows past the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A new result only appears after an update cycle.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_UPDATE))
    else $error("result beat raised outside the update cycle");

  // A hit reported by the chain always lies below the count.
  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE && bus_found[CAPACITY]) |-> (CW'(bus_pos[CAPACITY]) < count_q))
    else $error("lookup hit beyond the entry count");

  // A committed delete shrinks the table by exactly one entry.
  a_delete_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act.del_en |=> (count_q == $past(count_q) - 1'b1))
    else $error("delete did not shrink the table by one");

endmodule

// ----- tb/tb_ordered_key_value_table.sv -----
`timescale 1ns / 1ps

module tb_ordered_key_value_table;
  import okvt_pkg::*;

  localparam int TABLE_CAPACITY = DEFAULT_CAPACITY;
  // Time a command beat takes to come out as a result beat.
  localparam int RESULT_LATENCY = TABLE_CAPACITY + 1;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_OFF_CYCLES = 400;

  // Command codes 5 to 7 have no meaning; the table must answer them with a range status.
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  entry_count;
    logic [KEY_W-1:0]  key;
    logic [WGT_W-1:0]  weight;
  } table_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CMD_W-1:0]   command_i;
  logic [KEY_W-1:0]   vertex_key_i;
  logic [WGT_W-1:0]   weight_bits_i;
  logic [RPOS_W-1:0]  read_position_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [STAT_W-1:0]  status_o;
  logic [POS_W-1:0]   position_o;
  logic [CNT_W-1:0]   entry_count_o;
  logic [KEY_W-1:0]   key_out_o;
  logic [WGT_W-1:0]   weight_out_o;

  // Shadow copy of the table contents, updated whenever a command beat is accepted.
  logic [KEY_W-1:0] shadow_keys [TABLE_CAPACITY];
  logic [WGT_W-1:0] shadow_weights [TABLE_CAPACITY];
  int               shadow_count;

  table_result_t expected_results [$];

  int  error_count;
  int  commands_accepted;
  int  results_checked;
  int  status_tally [5];
  int  cycle_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_request;
  int  stall_left;
  bit  growing;

  ordered_key_value_table #(
    .CAPACITY(TABLE_CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .vertex_key_i   (vertex_key_i),
    .weight_bits_i  (weight_bits_i),
    .read_position_i(read_position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .position_o     (position_o),
    .entry_count_o  (entry_count_o),
    .key_out_o      (key_out_o),
    .weight_out_o   (weight_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Slot of a key among the live entries, or -1 when it is absent.
  function automatic int find_key(logic [KEY_W-1:0] key);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one command to the shadow table and returns the result it should give.
  function automatic table_result_t table_apply(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                                logic [WGT_W-1:0] weight,
                                                logic [RPOS_W-1:0] rpos);
    table_result_t r;
    int            slot;
    r = '0;
    slot = find_key(key);
    case (cmd)
      CMD_ADD: begin
        if (slot >= 0) begin
          r.status = STAT_PRESENT;
          r.position = POS_W'(slot);
          r.key = shadow_keys[slot];
          r.weight = shadow_weights[slot];
        end else if (shadow_count >= TABLE_CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_weights[shadow_count] = weight;
          r.status = STAT_DONE;
          r.position = POS_W'(shadow_count);
          r.key = key;
          r.weight = weight;
          shadow_count++;
        end
      end
      CMD_SET: begin
        if (slot >= 0) begin
          shadow_weights[slot] = weight;
          r.status = STAT_DONE;
          r.position = POS_W'(slot);
          r.key = shadow_keys[slot];
          r.weight = weight;
        end else begin
          r.status = STAT_MISSING;
        end
      end
      CMD_DELETE: begin
        if (slot >= 0) begin
          r.status = STAT_DONE;
          r.position = POS_W'(slot);
          r.key = shadow_keys[slot];
          r.weight = shadow_weights[slot];
          // Later entries slide down by one so the order is kept.
          for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_weights[i] = shadow_weights[i + 1];
          end
          shadow_count--;
        end else begin
          r.status = STAT_MISSING;
        end
      end
      CMD_SEARCH: begin
        if (slot >= 0) begin
          r.status = STAT_DONE;
          r.position = POS_W'(slot);
          r.key = shadow_keys[slot];
          r.weight = shadow_weights[slot];
        end else begin
          r.status = STAT_MISSING;
        end
      end
      CMD_READ: begin
        r.position = rpos;
        if (int'(rpos) < shadow_count) begin
          r.status = STAT_DONE;
          r.key = shadow_keys[rpos];
          r.weight = shadow_weights[rpos];
        end else begin
          r.status = STAT_RANGE;
        end
      end
      default: begin
        r.status = STAT_RANGE;
      end
    endcase
    r.entry_count = CNT_W'(shadow_count);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'($urandom);
  endfunction

  function automatic logic [RPOS_W-1:0] rand_pos();
    return RPOS_W'($urandom);
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] key;
    do key = rand_key(); while (find_key(key) >= 0);
    return key;
  endfunction

  function automatic logic [KEY_W-1:0] stored_key();
    if (shadow_count == 0) return rand_key();
    return shadow_keys[$urandom_range(0, shadow_count - 1)];
  endfunction

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0h, actual %0h", name, expected, actual);
      error_count++;
    end
  endtask

  // Result side first, then the command side: a command beat can never produce its
  // result beat on the edge where it is accepted.
  always @(posedge clk_i) begin
    table_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command waiting: status %0h", status_o);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", 32'(exp_r.status), 32'(status_o));
          check_field("position", 32'(exp_r.position), 32'(position_o));
          check_field("entry_count", 32'(exp_r.entry_count), 32'(entry_count_o));
          check_field("key_out", 32'(exp_r.key), 32'(key_out_o));
          check_field("weight_out", exp_r.weight, weight_out_o);
          results_checked++;
          if (exp_r.status <= STAT_RANGE) status_tally[exp_r.status]++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(table_apply(command_i, vertex_key_i, weight_bits_i,
                                               read_position_i));
        commands_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result receiver. Each cycle it stalls with the current odds; a hold-off request
  // overrides the dice with one long unbroken stall.
  initial begin
    out_stall_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Offers one command beat and returns at the falling edge after it was taken. Valid is
  // left high so that a following beat can go out back to back; end_burst lowers it.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                              logic [WGT_W-1:0] weight, logic [RPOS_W-1:0] rpos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    vertex_key_i <= key;
    weight_bits_i <= weight;
    read_position_i <= rpos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_empty_table();
    send_command(CMD_SEARCH, '0, $urandom, rand_pos());
    send_command(CMD_SET, '1, '1, rand_pos());
    send_command(CMD_DELETE, rand_key(), $urandom, rand_pos());
    send_command(CMD_READ, rand_key(), $urandom, '0);
    send_command(CMD_READ, rand_key(), $urandom, '1);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
      send_command(CMD_W'(c), rand_key(), $urandom, rand_pos());
    end_burst();
    wait_for_results();
  endtask

  // Extreme keys and weights, a duplicate add, and deletes at the middle, head and tail.
  task automatic test_basic_entries();
    logic [KEY_W-1:0] mid_key;
    mid_key = 16'h5a3c;
    send_command(CMD_ADD, '0, '0, rand_pos());
    send_command(CMD_ADD, '1, '1, rand_pos());
    send_command(CMD_ADD, mid_key, $urandom, rand_pos());
    send_command(CMD_ADD, '1, '0, rand_pos());
    send_command(CMD_SET, '0, '1, rand_pos());
    send_command(CMD_SEARCH, '1, $urandom, rand_pos());
    send_command(CMD_READ, rand_key(), $urandom, RPOS_W'(2));
    send_command(CMD_READ, rand_key(), $urandom, RPOS_W'(3));
    send_command(CMD_DELETE, '1, $urandom, rand_pos());
    send_command(CMD_READ, rand_key(), $urandom, RPOS_W'(1));
    send_command(CMD_DELETE, '0, $urandom, rand_pos());
    send_command(CMD_DELETE, mid_key, $urandom, rand_pos());
    end_burst();
    wait_for_results();
  endtask

  task automatic test_full_table();
    while (shadow_count < TABLE_CAPACITY) send_command(CMD_ADD, fresh_key(), $urandom, rand_pos());
    send_command(CMD_ADD, fresh_key(), $urandom, rand_pos());
    send_command(CMD_ADD, stored_key(), $urandom, rand_pos());
    send_command(CMD_READ, rand_key(), $urandom, RPOS_W'(TABLE_CAPACITY - 1));
    send_command(CMD_SET, shadow_keys[TABLE_CAPACITY - 1], $urandom, rand_pos());
    send_command(CMD_DELETE, shadow_keys[TABLE_CAPACITY - 1], $urandom, rand_pos());
    send_command(CMD_DELETE, shadow_keys[0], $urandom, rand_pos());
    send_command(CMD_SEARCH, stored_key(), $urandom, rand_pos());
    end_burst();
    wait_for_results();
  endtask

  // Mostly meaningful traffic on keys that are stored, with a share of noise: unused
  // command codes and arbitrary keys. The table swings between filling up and emptying.
  task automatic send_random_command();
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [RPOS_W-1:0] rpos;
    int                roll;
    if (shadow_count == TABLE_CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
    else if (shadow_count == 0) growing = 1'b1;
    else if ($urandom_range(0, 99) < 2) growing = !growing;
    key = rand_key();
    rpos = rand_pos();
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    end else if (roll < 12) begin
      cmd = CMD_W'($urandom_range(CMD_ADD, CMD_READ));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 45) cmd = growing ? CMD_ADD : CMD_DELETE;
      else if (roll < 55) cmd = growing ? CMD_DELETE : CMD_ADD;
      else if (roll < 70) cmd = CMD_SET;
      else if (roll < 85) cmd = CMD_SEARCH;
      else cmd = CMD_READ;
      if (cmd == CMD_ADD) begin
        if ($urandom_range(0, 3) == 0) key = stored_key();
      end else if (cmd == CMD_READ) begin
        if (shadow_count > 0 && $urandom_range(0, 4) != 0)
          rpos = RPOS_W'($urandom_range(0, shadow_count - 1));
      end else if ($urandom_range(0, 99) < 85) begin
        key = stored_key();
      end
    end
    send_command(cmd, key, $urandom, rpos);
  endtask

  // The receiver holds off for a long stretch while commands keep coming, so the result
  // register and the lookup both fill and the table has to stall its input.
  task automatic test_backpressure();
    hold_request = HOLD_OFF_CYCLES;
    repeat (10) send_random_command();
    end_burst();
    wait_for_results();
  endtask

  task automatic test_random_traffic(int items, int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    repeat (items) send_random_command();
    end_burst();
    wait_for_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_ADD;
    vertex_key_i = '0;
    weight_bits_i = '0;
    read_position_i = '0;
    shadow_count = 0;
    error_count = 0;
    commands_accepted = 0;
    results_checked = 0;
    cycle_count = 0;
    hold_request = 0;
    growing = 1'b1;
    send_idle_pct = 30;
    recv_stall_pct = 58;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_basic_entries();
    test_full_table();
    test_backpressure();
    test_random_traffic(333, 30, 58);
    test_random_traffic(333, 58, 30);
    test_random_traffic(333, 0, 0);

    // Any stray result beat would show up during this wait after the last one.
    repeat (RESULT_LATENCY + 8) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    $display("Ran %0d command beats and checked %0d result beats in %0d cycles.",
             commands_accepted, results_checked, cycle_count);
    $display("Statuses seen: done %0d, missing %0d, present %0d, full %0d, range %0d.",
             status_tally[STAT_DONE], status_tally[STAT_MISSING], status_tally[STAT_PRESENT],
             status_tally[STAT_FULL], status_tally[STAT_RANGE]);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
